// ----- hw/rtl/icu_pkg.sv -----
// ----------------------------------------------------------------------------
// icu_pkg
// Shared types and constants for the integer calculator unit.
// ----------------------------------------------------------------------------
package icu_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POWA = 3'd4;
  localparam logic [2:0] OP_POWB = 3'd5;
  localparam logic [2:0] OP_FACT = 3'd6;
  localparam logic [2:0] OP_MOD  = 3'd7;

  localparam logic [3:0] ST_OK   = 4'd0;
  localparam logic [3:0] ST_OVF  = 4'd1;
  localparam logic [3:0] ST_DIV0 = 4'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [3:0]  status_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic [3:0]  status_out;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture operands
    logic div_step; // one restoring divide step
    logic mul_step; // one power/factorial multiply
    logic finish;   // form the result
  } icu_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_div;   // divide or modulo with nonzero divisor
    logic is_iter;  // power or factorial request
    logic div_last; // last divide step in flight
    logic mul_done; // multiply loop has ended
  } icu_sts_t;

endpackage

// ----- hw/rtl/integer_calculator_unit_top.sv -----
// Integer calculator unit: add/sub/mul/div/mod, powers and factorial.
// Sequence: load on start, decode, then restoring divide steps for
// divide/modulo (one restoring step per cycle) or a multiply loop for powers
// and factorial, then finish; add/sub/mul and divide by zero go straight to finish.
// One item at a time: busy stays high until the result strobe.
// Synchronous active-low reset idles the sequencer and drops any item in flight.
module integer_calculator_unit_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  icu_pkg::in_item_t  in_item,
  output logic               out_valid,
  output icu_pkg::out_item_t out_item
);

  icu_pkg::icu_cmd_t cmd;
  icu_pkg::icu_sts_t sts;

  icu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  icu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/icu_ctrl.sv -----
// ----------------------------------------------------------------------------
// icu_ctrl
// Sequencer: picks the path per item and steps the datapath.
// ----------------------------------------------------------------------------
module icu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output icu_pkg::icu_cmd_t cmd,
  input  icu_pkg::icu_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_div) state_nxt = S_DIV;
        else if (sts.is_iter) state_nxt = S_MUL;
        else state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_MUL: begin
        if (sts.mul_done) state_nxt = S_FIN;
        else cmd.mul_step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/icu_dp.sv -----
// ----------------------------------------------------------------------------
// icu_dp
// Datapath: operand registers, serial divider, multiply loop, result.
// ----------------------------------------------------------------------------
module icu_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  icu_pkg::in_item_t  in_item,
  input  icu_pkg::icu_cmd_t  cmd,
  output icu_pkg::icu_sts_t  sts,
  output logic               out_valid,
  output icu_pkg::out_item_t out_item
);

  localparam int CW = $clog2(DATA_WIDTH + 2);
  localparam logic [DATA_WIDTH-1:0] LIMIT = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [2:0]            op_r;
  logic [DATA_WIDTH-1:0] a_r, b_r;
  logic [3:0]            st_r;
  logic [DATA_WIDTH-1:0] quo_r, rem_r;
  logic [CW-1:0]         cnt_r;
  logic [DATA_WIDTH-1:0] base_r, expo_r;
  logic [DATA_WIDTH-1:0] acc_r;
  logic                  ovf_r, mdone_r;
  logic                  out_valid_r;
  icu_pkg::out_item_t    out_r;

  logic [DATA_WIDTH:0]     rem_sh;
  logic [DATA_WIDTH:0]     rem_sub;
  logic [2*DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0]   factor;
  logic [DATA_WIDTH-1:0]   res_nxt;
  logic [3:0]              st_nxt;
  logic [DATA_WIDTH-1:0]   in_a, in_b;
  logic [DATA_WIDTH-1:0]   prod_lo;
  logic [2*DATA_WIDTH-1:0] mprod;

  assign in_a = in_item.operand_a[DATA_WIDTH-1:0];
  assign in_b = in_item.operand_b[DATA_WIDTH-1:0];

  assign rem_sh  = {rem_r, quo_r[DATA_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  // factorial multiplies by the running index held in expo_r
  assign factor = (op_r == icu_pkg::OP_FACT) ? expo_r : base_r;
  assign prod   = acc_r * factor;

  assign sts.is_div   = (op_r == icu_pkg::OP_DIV || op_r == icu_pkg::OP_MOD) && (b_r != '0);
  assign sts.is_iter  = (op_r == icu_pkg::OP_POWA || op_r == icu_pkg::OP_POWB ||
                         op_r == icu_pkg::OP_FACT);
  assign sts.div_last = (cnt_r == CW'(1));
  assign sts.mul_done = mdone_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_item.req_type;
      a_r   <= in_a;
      b_r   <= in_b;
      st_r  <= in_item.status_in;
      quo_r <= in_a;
      rem_r <= '0;
      cnt_r <= CW'(DATA_WIDTH);
      acc_r <= DATA_WIDTH'(1);
      ovf_r <= 1'b0;
      unique case (in_item.req_type)
        icu_pkg::OP_POWA: begin
          base_r  <= in_a;
          expo_r  <= in_b;
          mdone_r <= (in_b == '0) || (in_a <= DATA_WIDTH'(1));
        end
        icu_pkg::OP_POWB: begin
          base_r  <= in_b;
          expo_r  <= in_a;
          mdone_r <= (in_a == '0) || (in_b <= DATA_WIDTH'(1));
        end
        default: begin
          // factorial: expo_r counts 2..n, base_r holds n
          base_r  <= in_a;
          expo_r  <= DATA_WIDTH'(2);
          mdone_r <= (in_a < DATA_WIDTH'(2));
        end
      endcase
    end else if (cmd.div_step) begin
      if (!rem_sub[DATA_WIDTH]) begin
        rem_r <= rem_sub[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
    end else if (cmd.mul_step) begin
      // acc stays below LIMIT before each step, so prod fits 2*DATA_WIDTH
      if (prod >= {{DATA_WIDTH{1'b0}}, LIMIT}) begin
        acc_r   <= LIMIT;
        ovf_r   <= 1'b1;
        mdone_r <= 1'b1;
      end else begin
        acc_r <= prod[DATA_WIDTH-1:0];
        if (op_r == icu_pkg::OP_FACT) begin
          expo_r  <= expo_r + DATA_WIDTH'(1);
          mdone_r <= (expo_r >= base_r);
        end else begin
          expo_r  <= expo_r - DATA_WIDTH'(1);
          mdone_r <= (expo_r == DATA_WIDTH'(1));
        end
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    st_nxt  = st_r;
    case (op_r)
      icu_pkg::OP_ADD: res_nxt = a_r + b_r;
      icu_pkg::OP_SUB: res_nxt = a_r - b_r;
      icu_pkg::OP_MUL: res_nxt = prod_lo;
      icu_pkg::OP_DIV, icu_pkg::OP_MOD: begin
        if (b_r == '0) begin
          st_nxt = icu_pkg::ST_DIV0;
        end else begin
          res_nxt = (op_r == icu_pkg::OP_DIV) ? quo_r : rem_r;
        end
      end
      default: begin
        if (op_r == icu_pkg::OP_POWA && b_r == '0) res_nxt = DATA_WIDTH'(1);
        else if (op_r == icu_pkg::OP_POWB && a_r == '0) res_nxt = DATA_WIDTH'(1);
        else res_nxt = (base_r == '0 && op_r != icu_pkg::OP_FACT) ? '0 : acc_r;
        st_nxt = ovf_r ? icu_pkg::ST_OVF : icu_pkg::ST_OK;
      end
    endcase
  end

  // plain wrapping multiply for the mul opcode, registered from operands
  assign mprod = a_r * b_r;
  always_ff @(posedge clk) begin
    prod_lo <= mprod[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.finish;
    if (cmd.finish) begin
      out_r.result     <= 32'(res_nxt);
      out_r.status_out <= st_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- test/integer_calculator_unit_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_calculator_unit_top_tb
// Drives opcode/operand beats into the calculator, predicts each result
// (wrapping arithmetic, saturating powers and factorial, divide-by-zero
// status) and compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module integer_calculator_unit_top_tb;

  localparam logic [63:0] SAT_LIMIT = 64'd2147483647;
  localparam int          CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  icu_pkg::in_item_t  in_item;
  logic               out_valid;
  icu_pkg::out_item_t out_item;

  icu_pkg::out_item_t pending_results[$];
  int                 fail_count;
  int                 cycle_count;
  int                 result_count;
  int                 beat_count;

  integer_calculator_unit_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sat_pow(logic [63:0] base, logic [63:0] expo,
                                          output logic ovf);
    logic [63:0] acc;
    ovf = 1'b0;
    acc = 64'd1;
    if (expo == 0) return 64'd1;
    if (base == 0) return 64'd0;
    if (base == 1) return 64'd1;
    for (int i = 0; i < expo && i <= 32; i++) begin
      acc = acc * base;
      if (acc >= SAT_LIMIT) begin
        ovf = 1'b1;
        return SAT_LIMIT;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] sat_fact(logic [63:0] n, output logic ovf);
    logic [63:0] acc;
    ovf = 1'b0;
    acc = 64'd1;
    for (logic [63:0] i = 2; i <= n; i++) begin
      acc = acc * i;
      if (acc >= SAT_LIMIT) begin
        ovf = 1'b1;
        return SAT_LIMIT;
      end
    end
    return acc;
  endfunction

  function automatic icu_pkg::out_item_t calc_result(icu_pkg::in_item_t req);
    icu_pkg::out_item_t r;
    logic               ovf;
    logic [63:0]        v;
    r.status_out = req.status_in;
    r.result     = '0;
    case (req.req_type)
      icu_pkg::OP_ADD: r.result = req.operand_a + req.operand_b;
      icu_pkg::OP_SUB: r.result = req.operand_a - req.operand_b;
      icu_pkg::OP_MUL: r.result = req.operand_a * req.operand_b;
      icu_pkg::OP_DIV, icu_pkg::OP_MOD: begin
        if (req.operand_b == 0) begin
          r.status_out = icu_pkg::ST_DIV0;
        end else if (req.req_type == icu_pkg::OP_DIV) begin
          r.result = req.operand_a / req.operand_b;
        end else begin
          r.result = req.operand_a % req.operand_b;
        end
      end
      default: begin
        if (req.req_type == icu_pkg::OP_POWA)
          v = sat_pow(64'(req.operand_a), 64'(req.operand_b), ovf);
        else if (req.req_type == icu_pkg::OP_POWB)
          v = sat_pow(64'(req.operand_b), 64'(req.operand_a), ovf);
        else v = sat_fact(64'(req.operand_a), ovf);
        r.result     = v[31:0];
        r.status_out = ovf ? icu_pkg::ST_OVF : icu_pkg::ST_OK;
      end
    endcase
    return r;
  endfunction

  // directed rows; a typed-in result is checked against the predictor too
  typedef struct {
    icu_pkg::in_item_t  req;
    logic               typed;
    icu_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                         logic [3:0] st, logic typed = 0,
                         logic [31:0] res = 0, logic [3:0] sto = 0);
    dir_row_t row;
    row.req   = '{op, a, b, st};
    row.typed = typed;
    row.want  = '{res, sto};
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(icu_pkg::in_item_t req, logic allow_gap);
    if (allow_gap) begin
      while ($urandom_range(99) < 16) @(negedge clk);
    end
    // hold the beat back while the previous item is still in flight
    while (busy) @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    pending_results.push_back(calc_result(req));
    beat_count++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  // check each result strobe against the oldest prediction
  always @(posedge clk) begin
    icu_pkg::out_item_t exp_res;
    cycle_count++;
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with none expected: result=%0h status=%0h",
               out_item.result, out_item.status_out);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.result !== exp_res.result) begin
          $error("result: expected %0h actual %0h", exp_res.result, out_item.result);
          fail_count++;
        end
        if (out_item.status_out !== exp_res.status_out) begin
          $error("status_out: expected %0h actual %0h",
                 exp_res.status_out, out_item.status_out);
          fail_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    icu_pkg::in_item_t req;
    int                pick;
    int                drain;
    fail_count   = 0;
    cycle_count  = 0;
    result_count = 0;
    beat_count   = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(icu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1, 4'hF, 1, 32'd0, 4'hF);
    add_row(icu_pkg::OP_SUB, 32'd0, 32'd1, 4'h5, 1, 32'hFFFF_FFFF, 4'h5);
    add_row(icu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hA, 1, 32'd1, 4'hA);
    add_row(icu_pkg::OP_DIV, 32'd1234, 32'd0, 4'h7, 1, 32'd0, icu_pkg::ST_DIV0);
    add_row(icu_pkg::OP_MOD, 32'hFFFF_FFFF, 32'd0, 4'h0, 1, 32'd0, icu_pkg::ST_DIV0);
    add_row(icu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd1, 4'h3);
    add_row(icu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h9);
    add_row(icu_pkg::OP_MOD, 32'd1000, 32'd7, 4'hC);
    add_row(icu_pkg::OP_POWA, 32'd0, 32'd0, 4'hF, 1, 32'd1, icu_pkg::ST_OK);
    add_row(icu_pkg::OP_POWA, 32'd0, 32'd5, 4'hF, 1, 32'd0, icu_pkg::ST_OK);
    add_row(icu_pkg::OP_POWB, 32'hFFFF_FFFF, 32'd1, 4'h4, 1, 32'd1, icu_pkg::ST_OK);
    add_row(icu_pkg::OP_POWA, 32'd2, 32'd31, 4'h0, 1, 32'h7FFF_FFFF, icu_pkg::ST_OVF);
    add_row(icu_pkg::OP_POWA, 32'd2, 32'd30, 4'h0);
    add_row(icu_pkg::OP_POWA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 1, 32'h7FFF_FFFF,
            icu_pkg::ST_OVF);
    add_row(icu_pkg::OP_POWB, 32'd3, 32'd7, 4'h2);
    add_row(icu_pkg::OP_FACT, 32'd0, 32'd0, 4'h6, 1, 32'd1, icu_pkg::ST_OK);
    add_row(icu_pkg::OP_FACT, 32'd12, 32'd0, 4'h1);
    add_row(icu_pkg::OP_FACT, 32'd13, 32'd0, 4'h1, 1, 32'h7FFF_FFFF, icu_pkg::ST_OVF);
    add_row(icu_pkg::OP_FACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h8, 1, 32'h7FFF_FFFF,
            icu_pkg::ST_OVF);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed && calc_result(dir_rows[i].req) !== dir_rows[i].want) begin
        $error("directed row %0d: expected %0h actual prediction %0h", i,
               dir_rows[i].want, calc_result(dir_rows[i].req));
        fail_count++;
      end
      send_beat(dir_rows[i].req, 1'b0);
    end

    for (int n = 0; n < 400; n++) begin
      req.req_type  = 3'($urandom_range(7));
      req.status_in = 4'($urandom);
      pick = $urandom_range(9);
      req.operand_a = (pick < 4) ? $urandom_range(40) : $urandom;
      pick = $urandom_range(9);
      req.operand_b = (pick < 2) ? 32'd0 : (pick < 6) ? $urandom_range(40) : $urandom;
      // hold gaps off through a long middle stretch
      send_beat(req, !(n >= 150 && n < 250));
    end

    drain = 0;
    while (pending_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end

    $display("covered %0d beats, all eight opcodes, divide by zero and saturation",
             beat_count);
    $display("%0d results checked, %0d failures", result_count, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
